// ----- rtl/psau_pkg.sv -----
`timescale 1ns / 1ps

package psau_pkg;

    // Address field layout: fineY<<12 | ntY<<11 | ntX<<10 | coarseY<<5 | coarseX
    localparam int unsigned ADDR_W  = 15;
    localparam int unsigned DOT_W   = 9;
    localparam int unsigned LINE_W  = 9;
    localparam int unsigned DELAY_W = 3;

    localparam logic [ADDR_W-1:0] X_FIELDS = 15'h041F;
    localparam logic [ADDR_W-1:0] Y_FIELDS = 15'h7BE0;
    localparam logic [ADDR_W-1:0] ALL_ONES = 15'h7FFF;

    localparam logic [LINE_W-1:0] LINES_PER_FRAME_RST = 9'd262;

    // Dot positions that matter to the scroll logic
    localparam logic [DOT_W-1:0] DOT_Y_STEP    = 9'd256;
    localparam logic [DOT_W-1:0] DOT_X_COPY    = 9'd257;
    localparam logic [DOT_W-1:0] DOT_Y_FIRST   = 9'd280;
    localparam logic [DOT_W-1:0] DOT_Y_LAST    = 9'd304;
    localparam logic [DOT_W-1:0] DOT_PREFETCH  = 9'd320;
    localparam logic [DOT_W-1:0] DOT_PREF_LAST = 9'd336;

    localparam logic [4:0] COARSE_Y_WRAP = 5'd30;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef struct packed {
        logic                command;
        logic [DOT_W-1:0]    dot;
        logic [LINE_W-1:0]   scanline;
        logic                rendering_on;
        logic [ADDR_W-1:0]   temp_value;
        logic [DELAY_W-1:0]  delay_ticks;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] vram_address;
        logic              bus_update;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  live_address;
        logic [ADDR_W-1:0]  temp_address;
        logic [DELAY_W-1:0] delay_count;
    } t_scroll_state;

endpackage

// ----- rtl/psau_in_if.sv -----
`timescale 1ns / 1ps

interface psau_in_if import psau_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/psau_out_if.sv -----
`timescale 1ns / 1ps

interface psau_out_if import psau_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/ppu_scroll_address_unit.sv -----
`timescale 1ns / 1ps

// Scroll address unit: takes one request per clock while results are taken
// (dot ticks and loads of the temporary address) and returns one result per
// request, the live VRAM address after that request and a bus-update flag. The
// request is captured in an input register, and the single combinational update
// of the live/temporary address and delay counter lands in the result register.
// Both stages stall together when the result is not taken. Write lines_per_frame
// through i_cfg_we/i_cfg_data only while no request is in flight.
module ppu_scroll_address_unit import psau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LINE_W-1:0] i_cfg_data,
    psau_in_if.sink           i_in,
    psau_out_if.source        o_out
);

    logic              r_in_valid;
    t_in_item          r_in_item;
    logic              r_out_valid;
    t_out_item         r_out_item;
    t_scroll_state     r_state;
    logic [LINE_W-1:0] r_lines_per_frame;

    t_scroll_state     n_state;
    t_out_item         n_out_item;
    logic              advance;

    assign advance     = ~r_out_valid | o_out.ready;
    assign i_in.ready  = ~r_in_valid | advance;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out_item;

    psau_core u_core (
        .i_item            (r_in_item),
        .i_state           (r_state),
        .i_lines_per_frame (r_lines_per_frame),
        .o_state           (n_state),
        .o_result          (n_out_item)
    );

    // Hold frame length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines_per_frame <= LINES_PER_FRAME_RST;
        end else if (i_cfg_we) begin
            r_lines_per_frame <= i_cfg_data;
        end
    end

    // Capture incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.payload;
        end
    end

    // Advance scroll state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

// ----- rtl/psau_core.sv -----
`timescale 1ns / 1ps

module psau_core import psau_pkg::*; (
    input  t_in_item          i_item,
    input  t_scroll_state     i_state,
    input  logic [LINE_W-1:0] i_lines_per_frame,
    output t_scroll_state     o_state,
    output t_out_item         o_result
);

    function automatic logic [ADDR_W-1:0] step_x(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        r      = a;
        r[4:0] = a[4:0] + 5'd1;
        if (a[4:0] == 5'd31) begin
            r[10] = ~a[10];
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] step_y(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        logic [4:0]        cy;
        r        = a;
        r[14:12] = a[14:12] + 3'd1;
        cy       = a[9:5] + 5'd1;
        if (a[14:12] == 3'd7) begin
            if (cy == COARSE_Y_WRAP) begin
                cy    = 5'd0;
                r[11] = ~a[11];
            end
            r[9:5] = cy;
        end
        return r;
    endfunction

    logic [LINE_W-1:0] pre_line;
    logic              dot_x8;
    logic [ADDR_W-1:0] live;
    logic [ADDR_W-1:0] temp;
    logic [ADDR_W-1:0] keep;
    logic              mx;
    logic              my;
    logic              bus;

    assign pre_line = i_lines_per_frame - LINE_W'(1);
    assign dot_x8   = (i_item.dot[2:0] == 3'd0) && (i_item.dot != '0);

    always_comb begin
        live   = i_state.live_address;
        temp   = i_state.temp_address;
        keep   = ALL_ONES;
        mx     = 1'b0;
        my     = 1'b0;
        bus    = 1'b0;
        o_state.delay_count = i_state.delay_count;

        if (i_item.command == CMD_LOAD) begin
            // Load: replace temporary address and delay, no stepping
            temp                = i_item.temp_value;
            o_state.delay_count = i_item.delay_ticks;
        end else begin
            // Scroll step while rendering
            if (i_item.rendering_on) begin
                if (i_item.dot == '0) begin
                    live = i_state.live_address;
                end else if (i_item.dot <= DOT_Y_STEP) begin
                    if (dot_x8) begin
                        live = step_x(live);
                        if (i_item.dot == DOT_Y_STEP) begin
                            live = step_y(live);
                        end
                    end
                end else if (i_item.dot == DOT_X_COPY) begin
                    live = (live & ~X_FIELDS) | (temp & X_FIELDS);
                end else if (i_item.scanline == pre_line && i_item.dot >= DOT_Y_FIRST &&
                             i_item.dot <= DOT_Y_LAST) begin
                    live = (live & ~Y_FIELDS) | (temp & Y_FIELDS);
                end else if (i_item.dot > DOT_PREFETCH && i_item.dot <= DOT_PREF_LAST &&
                             dot_x8) begin
                    live = step_x(live);
                end
            end

            // Count down the transfer delay, copy on expiry
            if (i_state.delay_count != '0) begin
                o_state.delay_count = i_state.delay_count - DELAY_W'(1);
                if (i_state.delay_count == DELAY_W'(1)) begin
                    mx = i_item.rendering_on && dot_x8 &&
                         (i_item.dot <= DOT_Y_STEP || i_item.dot > DOT_PREFETCH);
                    my = i_item.rendering_on && (i_item.dot == DOT_Y_STEP);
                    if (mx) begin
                        keep = keep & ~X_FIELDS;
                    end
                    if (my) begin
                        keep = keep & ~Y_FIELDS;
                    end
                    temp = temp & (live | keep);
                    live = temp;
                    bus  = ~i_item.rendering_on;
                end
            end
        end

        o_state.live_address  = live;
        o_state.temp_address  = temp;
        o_result.vram_address = live;
        o_result.bus_update   = bus;
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import psau_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [LINE_W-1:0] i_cfg_data;

    psau_in_if  in_if ();
    psau_out_if out_if ();

    ppu_scroll_address_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Scroll state as the testbench sees it
    logic [LINE_W-1:0]  frame_lines;
    logic [ADDR_W-1:0]  live_addr;
    logic [ADDR_W-1:0]  temp_addr;
    logic [DELAY_W-1:0] delay_cnt;

    t_out_item expected_addr_q[$];

    int  err_count      = 0;
    int  sent_count     = 0;
    int  result_count   = 0;
    int  setting_count  = 0;
    int  rx_hold_cycles = 0;
    bit  tx_idle_on     = 1'b1;
    bit  rx_idle_on     = 1'b1;

    always #10 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] step_coarse_x(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        r = a;
        r[4:0] = a[4:0] + 5'd1;
        if (r[4:0] == 5'd0) r[10] = ~r[10];
        return r;
    endfunction

    // Fine Y carries into coarse Y; coarse Y wraps at 30 and flips the vertical table
    function automatic logic [ADDR_W-1:0] step_fine_y(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        logic [4:0]        cy;
        r = a;
        r[14:12] = a[14:12] + 3'd1;
        if (r[14:12] == 3'd0) begin
            cy = a[9:5] + 5'd1;
            if (cy == COARSE_Y_WRAP) begin
                cy    = 5'd0;
                r[11] = ~r[11];
            end
            r[9:5] = cy;
        end
        return r;
    endfunction

    // Advance the scroll state by one request and queue the address it should give
    task automatic predict_scroll(input t_in_item it);
        logic [LINE_W-1:0] pre_line;
        logic [ADDR_W-1:0] keep;
        t_out_item         res;
        pre_line       = frame_lines - LINE_W'(1);
        res.bus_update = 1'b0;
        if (it.command == CMD_LOAD) begin
            temp_addr = it.temp_value;
            delay_cnt = it.delay_ticks;
        end else begin
            if (it.rendering_on && it.dot != '0) begin
                if (it.dot <= DOT_Y_STEP) begin
                    if (it.dot[2:0] == 3'd0) begin
                        live_addr = step_coarse_x(live_addr);
                        if (it.dot == DOT_Y_STEP) live_addr = step_fine_y(live_addr);
                    end
                end else if (it.dot == DOT_X_COPY) begin
                    live_addr = (live_addr & ~X_FIELDS) | (temp_addr & X_FIELDS);
                end else if (it.scanline == pre_line && it.dot >= DOT_Y_FIRST &&
                             it.dot <= DOT_Y_LAST) begin
                    live_addr = (live_addr & ~Y_FIELDS) | (temp_addr & Y_FIELDS);
                end else if (it.dot > DOT_PREFETCH && it.dot <= DOT_PREF_LAST &&
                             it.dot[2:0] == 3'd0) begin
                    live_addr = step_coarse_x(live_addr);
                end
            end
            // Count down the pending transfer; on expiry merge and copy
            if (delay_cnt != '0) begin
                delay_cnt = delay_cnt - DELAY_W'(1);
                if (delay_cnt == '0) begin
                    keep = ALL_ONES;
                    if (it.rendering_on && it.dot != '0 && it.dot[2:0] == 3'd0 &&
                        (it.dot <= DOT_Y_STEP || it.dot > DOT_PREFETCH))
                        keep &= ~X_FIELDS;
                    if (it.rendering_on && it.dot == DOT_Y_STEP)
                        keep &= ~Y_FIELDS;
                    temp_addr = temp_addr & (live_addr | keep);
                    live_addr = temp_addr;
                    if (!it.rendering_on) res.bus_update = 1'b1;
                end
            end
        end
        res.vram_address = live_addr;
        expected_addr_q.push_back(res);
    endtask

    // Ticks carry junk in the load-only fields
    function automatic t_in_item make_tick(input int d, input int l, input bit rend);
        t_in_item it;
        it.command      = CMD_TICK;
        it.dot          = d[DOT_W-1:0];
        it.scanline     = l[LINE_W-1:0];
        it.rendering_on = rend;
        it.temp_value   = ADDR_W'($urandom_range(0, 32767));
        it.delay_ticks  = DELAY_W'($urandom_range(0, 7));
        return it;
    endfunction

    function automatic t_in_item make_load(input int value, input int ticks);
        t_in_item it;
        it.command      = CMD_LOAD;
        it.dot          = DOT_W'($urandom_range(0, 511));
        it.scanline     = LINE_W'($urandom_range(0, 511));
        it.rendering_on = 1'($urandom_range(0, 1));
        it.temp_value   = value[ADDR_W-1:0];
        it.delay_ticks  = ticks[DELAY_W-1:0];
        return it;
    endfunction

    // Offer one request, wait for it to be taken, then maybe idle
    task automatic send_request(input t_in_item it);
        int gap;
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        do @(posedge i_clk); while (!in_if.ready);
        predict_scroll(it);
        sent_count++;
        if (tx_idle_on) begin
            gap = pick_gap();
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drop valid and let every outstanding result come back
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_addr_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_frame_lines(input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[LINE_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        frame_lines  = value[LINE_W-1:0];
        setting_count++;
    endtask

    // Runs of consecutive dots around the interesting spots, loads mixed in, some noise
    task automatic run_scroll_traffic(input int n_items);
        int                sent;
        int                run_len;
        int                k;
        int                line;
        int                dotpos;
        bit                rend;
        t_in_item          it;
        logic [LINE_W-1:0] pre_line;
        sent = 0;
        while (sent < n_items) begin
            pre_line = frame_lines - LINE_W'(1);
            if ($urandom_range(0, 99) < 8) begin
                it.command      = 1'($urandom_range(0, 1));
                it.dot          = DOT_W'($urandom_range(0, 511));
                it.scanline     = LINE_W'($urandom_range(0, 511));
                it.rendering_on = 1'($urandom_range(0, 1));
                it.temp_value   = ADDR_W'($urandom_range(0, 32767));
                it.delay_ticks  = DELAY_W'($urandom_range(0, 7));
                send_request(it);
                sent++;
            end else begin
                line = ($urandom_range(0, 3) == 0) ? int'(pre_line)
                                                   : int'($urandom_range(0, 311));
                case ($urandom_range(0, 5))
                    0: dotpos = 0;
                    1: dotpos = $urandom_range(236, 256);
                    2: dotpos = $urandom_range(270, 300);
                    3: dotpos = $urandom_range(312, 336);
                    default: dotpos = $urandom_range(0, 340);
                endcase
                rend    = ($urandom_range(0, 7) != 0);
                run_len = $urandom_range(4, 40);
                for (k = 0; k < run_len && sent < n_items; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        it = make_load($urandom_range(0, 32767), $urandom_range(0, 7));
                    end else begin
                        it = make_tick(dotpos, line, rend);
                        if (dotpos >= 340) begin
                            dotpos = 0;
                            line   = (line >= 311) ? 0 : line + 1;
                        end else begin
                            dotpos++;
                        end
                    end
                    send_request(it);
                    sent++;
                end
            end
        end
    endtask

    // Wraps, the carry chain, copies and the transfer merge at the default frame length
    task automatic test_directed();
        send_request(make_load(ALL_ONES, 1));
        send_request(make_tick(5, 0, 1'b0));
        send_request(make_tick(8, 0, 1'b1));
        send_request(make_tick(256, 0, 1'b1));
        send_request(make_load(15'h73A0, 1));
        send_request(make_tick(0, 0, 1'b0));
        send_request(make_tick(256, 10, 1'b1));
        send_request(make_load(15'h73C0, 1));
        send_request(make_tick(0, 20, 1'b1));
        send_request(make_tick(256, 20, 1'b1));
        send_request(make_load(15'h2B45, 0));
        send_request(make_tick(257, 30, 1'b1));
        send_request(make_tick(280, 261, 1'b1));
        send_request(make_tick(304, 261, 1'b1));
        send_request(make_tick(300, 100, 1'b1));
        send_request(make_tick(328, 100, 1'b1));
        send_request(make_tick(336, 100, 1'b1));
        send_request(make_tick(344, 100, 1'b1));
        send_request(make_load(ALL_ONES, 1));
        send_request(make_tick(256, 5, 1'b1));
        send_request(make_load(15'h1234, 2));
        send_request(make_tick(320, 5, 1'b1));
        send_request(make_tick(336, 5, 1'b1));
        send_request(make_tick(511, 311, 1'b1));
        send_request(make_tick(340, 311, 1'b0));
        wait_idle();
    endtask

    // Hold the result side off while requests keep coming, so both stages fill
    task automatic test_backpressure();
        tx_idle_on     = 1'b0;
        rx_hold_cycles = 300;
        run_scroll_traffic(60);
        tx_idle_on = 1'b1;
        wait_idle();
    endtask

    // Zero frame length puts the pre-render line at the top of the 9-bit range
    task automatic test_degenerate_frame();
        write_frame_lines(0);
        send_request(make_load(15'h5AA5, 0));
        send_request(make_tick(280, 511, 1'b1));
        send_request(make_tick(296, 511, 1'b1));
        send_request(make_tick(304, 510, 1'b1));
        run_scroll_traffic(150);
        wait_idle();
    endtask

    task automatic test_random_scroll();
        int lengths[3];
        int p;
        lengths[0] = 312;
        lengths[1] = $urandom_range(263, 311);
        lengths[2] = int'(LINES_PER_FRAME_RST);
        for (p = 0; p < 3; p++) begin
            write_frame_lines(lengths[p]);
            // Middle phase runs flat out on both sides
            tx_idle_on = (p != 1);
            rx_idle_on = (p != 1);
            run_scroll_traffic(500);
            wait_idle();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Result side: long hold on request, otherwise random stalls
    initial begin : rx_side
        int stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles != 0) begin
                out_if.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
                out_if.ready <= 1'b1;
            end else if (stall_left != 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else if (rx_idle_on && $urandom_range(0, 99) < 30) begin
                out_if.ready <= 1'b0;
                stall_left = pick_gap();
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Compare each result against the oldest expectation
    always @(posedge i_clk) begin : chk_results
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.payload;
            result_count++;
            if (expected_addr_q.size() == 0) begin
                err_count++;
                if (err_count < 40)
                    $display("%0t: unexpected result, expected none, actual addr %h bus %b",
                             $time, got.vram_address, got.bus_update);
            end else begin
                want = expected_addr_q.pop_front();
                if (got.vram_address !== want.vram_address) begin
                    err_count++;
                    if (err_count < 40)
                        $display("%0t: vram_address mismatch, expected %h actual %h",
                                 $time, want.vram_address, got.vram_address);
                end
                if (got.bus_update !== want.bus_update) begin
                    err_count++;
                    if (err_count < 40)
                        $display("%0t: bus_update mismatch, expected %b actual %b",
                                 $time, want.bus_update, got.bus_update);
                end
            end
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("Timeout with %0d results still outstanding", expected_addr_q.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin : main_seq
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        frame_lines   = LINES_PER_FRAME_RST;
        live_addr     = '0;
        temp_addr     = '0;
        delay_cnt     = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_degenerate_frame();
        test_random_scroll();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (expected_addr_q.size() != 0) err_count++;

        $display("Sent %0d requests and checked %0d results across %0d frame-length writes",
                 sent_count, result_count, setting_count);
        $display("Covered scroll steps, copies, delayed transfers, long stall; %0d errors",
                 err_count);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/psau_pkg.sv
rtl/psau_in_if.sv
rtl/psau_out_if.sv
rtl/psau_core.sv
rtl/ppu_scroll_address_unit.sv
verif/tb_top.sv
